[hdl/apan_pkg.sv]
`default_nettype none

package apan_pkg;

  // Shared multiplier: signed operands wide enough for a 32-bit sample
  localparam int MUL_W = 33;
  localparam int P_W   = 2 * MUL_W;

  typedef logic signed [MUL_W-1:0] mul_op_t;
  typedef logic signed [P_W-1:0]   mul_p_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PHASE_INC = 2'd0;
  localparam logic [1:0] REG_PAN_AMT   = 2'd1;
  localparam logic [1:0] REG_LEVEL_IN  = 2'd2;
  localparam logic [1:0] REG_LEVEL_OUT = 2'd3;

  // Odd Taylor coefficients of sin(pi/2*t), Q2.30
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172273;

  localparam int          HORNER_STEPS = 4;
  localparam logic [1:0]  HORNER_LAST  = 2'(HORNER_STEPS - 1);

  // Operation run through the shared multiplier
  typedef enum logic [6:0] {
    OP_LEV  = 7'b0000001,
    OP_SQ   = 7'b0000010,
    OP_HRN  = 7'b0000100,
    OP_SIN  = 7'b0001000,
    OP_MOD  = 7'b0010000,
    OP_GAIN = 7'b0100000,
    OP_OUT  = 7'b1000000
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       ch;       // 0 left, 1 right
    logic [1:0] hstep;    // Horner step
    logic       issue;    // load multiplier
    logic       write;    // take product into its target register
    logic       idle;
  } ctrl_t;

  // Coefficient subtracted at each Horner step, innermost first
  function automatic logic [31:0] horner_coef(input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = C7;
      2'd1:    c = C5;
      2'd2:    c = C3;
      default: c = C1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/apan_mul.sv]
`default_nettype none

module apan_mul (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire apan_pkg::mul_op_t a,
  input  wire apan_pkg::mul_op_t b,
  output apan_pkg::mul_p_t      p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

`default_nettype wire

[hdl/apan_ctrl.sv]
`default_nettype none

module apan_ctrl (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    out_free,
  output apan_pkg::ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t          state, state_next;
  apan_pkg::op_t   op, op_next;
  logic            ch, ch_next;
  logic [1:0]      hstep, hstep_next;
  logic            blocked;

  // Last write of a frame waits for the output register
  assign blocked = (op == apan_pkg::OP_OUT) && ch && !out_free;

  always_comb begin
    state_next = state;
    op_next    = op;
    ch_next    = ch;
    hstep_next = hstep;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_ISSUE;
          op_next    = apan_pkg::OP_LEV;
          ch_next    = 1'b0;
          hstep_next = 2'd0;
        end
      end
      S_ISSUE: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_ISSUE;
        case (op)
          apan_pkg::OP_LEV:  op_next = apan_pkg::OP_SQ;
          apan_pkg::OP_SQ: begin
            op_next    = apan_pkg::OP_HRN;
            hstep_next = 2'd0;
          end
          apan_pkg::OP_HRN: begin
            if (hstep == apan_pkg::HORNER_LAST) begin
              op_next = apan_pkg::OP_SIN;
            end else begin
              hstep_next = hstep + 2'd1;
            end
          end
          apan_pkg::OP_SIN:  op_next = apan_pkg::OP_MOD;
          apan_pkg::OP_MOD:  op_next = apan_pkg::OP_GAIN;
          apan_pkg::OP_GAIN: op_next = apan_pkg::OP_OUT;
          apan_pkg::OP_OUT: begin
            if (!ch) begin
              op_next = apan_pkg::OP_MOD;
              ch_next = 1'b1;
            end else if (blocked) begin
              state_next = S_WRITE;
            end else begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= apan_pkg::OP_LEV;
      ch    <= 1'b0;
      hstep <= 2'd0;
    end else begin
      state <= state_next;
      op    <= op_next;
      ch    <= ch_next;
      hstep <= hstep_next;
    end
  end

  always_comb begin
    ctrl.op    = op;
    ctrl.ch    = ch;
    ctrl.hstep = hstep;
    ctrl.issue = (state == S_ISSUE);
    ctrl.write = (state == S_WRITE) && !blocked;
    ctrl.idle  = (state == S_IDLE);
  end

endmodule

`default_nettype wire

[hdl/stereo_autopan_lfo_gain_core.sv]
`default_nettype none

// Stereo auto-panner with a sine LFO.
// Input channel: in_valid/in_stall carry one stereo word (sample_left,
// sample_right). Output channel: out_valid/out_stall carry the panned word
// (out_left, out_right). A word moves on a rising edge with valid high and
// stall low. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while the block is idle, and
// the block itself does not enforce this. One word takes 13 passes
// through a single shared 33x33 multiplier, each a load of the product
// and then a write back. in_stall is high while a word is in work, so a
// new word is taken only after the previous one has been written back.
// The output register lets the next word enter while the last result still
// waits; if out_stall holds the previous result, the final write back waits.
// Reset clears the LFO phase, sets pan depth to zero and both levels to
// unity, and empties the output register. No clearing pass is needed.
module stereo_autopan_lfo_gain_core #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_WIDTH    = 24
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           in_valid,
  output logic                                 in_stall,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] sample_left,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] sample_right,
  output logic                                 out_valid,
  input  wire  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       out_left,
  output logic signed [SAMPLE_WIDTH-1:0]       out_right,
  input  wire  logic                           cfg_we,
  input  wire  logic [1:0]                     cfg_index,
  input  wire  logic [30:0]                    cfg_data
);

  localparam int PW = apan_pkg::P_W;
  localparam int MW = apan_pkg::MUL_W;
  localparam int QB = SINE_TABLE_BITS - 2;
  localparam logic [QB:0] QSIZE = (QB+1)'(1) << QB;
  localparam logic signed [PW-1:0] Y_HI =
    {{(PW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0] Y_LO =
    {{(PW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // configuration
  logic [30:0] phase_increment;
  logic [15:0] pan_amount;
  logic [15:0] level_in;
  logic [15:0] level_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= 31'd0;
      pan_amount      <= 16'd0;
      level_in        <= 16'd4096;
      level_out       <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        apan_pkg::REG_PHASE_INC: phase_increment <= cfg_data;
        apan_pkg::REG_PAN_AMT:   pan_amount      <= cfg_data[15:0];
        apan_pkg::REG_LEVEL_IN:  level_in        <= cfg_data[15:0];
        apan_pkg::REG_LEVEL_OUT: level_out       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  apan_pkg::ctrl_t ctrl;
  logic            accept;
  logic            out_free;

  assign in_stall = !ctrl.idle;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  apan_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // phase and quarter-wave position
  logic [31:0]                  lfo_phase;
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [QB-1:0]                r;
  logic [QB:0]                  pos;

  assign idx = lfo_phase[31 -: SINE_TABLE_BITS];
  assign r   = idx[QB-1:0];
  assign pos = idx[QB] ? (QSIZE - {1'b0, r}) : {1'b0, r};

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= 32'd0;
    end else if (accept) begin
      lfo_phase <= lfo_phase + {1'b0, phase_increment};
    end
  end

  // working registers
  logic signed [SAMPLE_WIDTH-1:0] x_left, x_right, res_left;
  logic [30:0] t, t2;
  logic        quad_hi;
  logic [31:0] acc;
  logic [16:0] mag;
  logic [15:0] m;
  logic [19:0] lev;
  logic [20:0] g;

  always_ff @(posedge clk) begin
    if (accept) begin
      x_left  <= sample_left;
      x_right <= sample_right;
      t       <= {pos, {(32-SINE_TABLE_BITS){1'b0}}};
      quad_hi <= idx[SINE_TABLE_BITS-1];
    end
  end

  // LFO for the current channel; the right channel is half a turn ahead
  logic        neg;
  logic [17:0] u, u_rnd;
  logic [15:0] lfo;
  logic [15:0] amt;

  assign neg   = quad_hi ^ ctrl.ch;
  assign u     = neg ? (18'd65536 - {1'b0, mag}) : (18'd65536 + {1'b0, mag});
  assign u_rnd = u + 18'd2;
  assign lfo   = u_rnd[17:2];
  assign amt   = (pan_amount > 16'd32768) ? 16'd32768 : pan_amount;

  // operand select
  apan_pkg::mul_op_t              op_a, op_b;
  apan_pkg::mul_p_t               p;
  logic signed [SAMPLE_WIDTH-1:0] x_ch;

  assign x_ch = ctrl.ch ? x_right : x_left;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.op)
      apan_pkg::OP_LEV: begin
        op_a = {17'd0, level_in};
        op_b = {17'd0, level_out};
      end
      apan_pkg::OP_SQ: begin
        op_a = {2'd0, t};
        op_b = {2'd0, t};
      end
      apan_pkg::OP_HRN: begin
        op_a = (ctrl.hstep == 2'd0) ? {1'b0, apan_pkg::C9} : {1'b0, acc};
        op_b = {2'd0, t2};
      end
      apan_pkg::OP_SIN: begin
        op_a = {1'b0, acc};
        op_b = {2'd0, t};
      end
      apan_pkg::OP_MOD: begin
        op_a = {17'd0, amt};
        op_b = {17'd0, lfo};
      end
      apan_pkg::OP_GAIN: begin
        op_a = {17'd0, m};
        op_b = {13'd0, lev};
      end
      apan_pkg::OP_OUT: begin
        op_a = {{(MW-SAMPLE_WIDTH){x_ch[SAMPLE_WIDTH-1]}}, x_ch};
        op_b = {12'd0, g};
      end
      default: ;
    endcase
  end

  apan_mul u_mul (
    .clk (clk),
    .en  (ctrl.issue),
    .a   (op_a),
    .b   (op_b),
    .p   (p)
  );

  // write back
  logic [31:0]          lev_sum;
  logic [31:0]          s_rnd;
  logic [17:0]          s_sh;
  logic [31:0]          m_sum;
  logic [35:0]          g_sum;
  logic signed [PW-1:0] y_full;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  assign lev_sum = p[31:0] + 32'd2048;
  assign s_rnd   = {1'b0, p[60:30]} + 32'd8192;
  assign s_sh    = s_rnd[31:14];
  assign m_sum   = {1'b0, (16'd32768 - amt), 15'd0} + p[31:0] + 32'd16384;
  assign g_sum   = p[35:0] + 36'd16384;
  assign y_full  = (p + PW'(2048)) >>> 12;

  always_comb begin
    if (y_full > Y_HI) begin
      y_sat = Y_HI[SAMPLE_WIDTH-1:0];
    end else if (y_full < Y_LO) begin
      y_sat = Y_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = y_full[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      case (ctrl.op)
        apan_pkg::OP_LEV:  lev <= lev_sum[31:12];
        apan_pkg::OP_SQ:   t2  <= p[60:30];
        apan_pkg::OP_HRN:  acc <= apan_pkg::horner_coef(ctrl.hstep) - {1'b0, p[60:30]};
        apan_pkg::OP_SIN:  mag <= (s_sh > 18'd65536) ? 17'd65536 : s_sh[16:0];
        apan_pkg::OP_MOD:  m   <= m_sum[30:15];
        apan_pkg::OP_GAIN: g   <= g_sum[35:15];
        apan_pkg::OP_OUT: begin
          if (!ctrl.ch) begin
            res_left <= y_sat;
          end else begin
            out_left  <= res_left;
            out_right <= y_sat;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.write && (ctrl.op == apan_pkg::OP_OUT) && ctrl.ch) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[test/stereo_autopan_lfo_gain_core_test.sv]
`timescale 1ns / 1ps

module stereo_autopan_lfo_gain_core_test;

  localparam int TABLE_BITS = 10;
  localparam int SW         = 24;

  localparam logic [63:0] SIN_K1 = 64'd1686629713;
  localparam logic [63:0] SIN_K3 = 64'd693598668;
  localparam logic [63:0] SIN_K5 = 64'd85569306;
  localparam logic [63:0] SIN_K7 = 64'd5026995;
  localparam logic [63:0] SIN_K9 = 64'd172273;

  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] sample_left = '0;
  logic signed [SW-1:0] sample_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_left;
  logic signed [SW-1:0] out_right;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = apan_pkg::REG_PHASE_INC;
  logic [30:0] cfg_data = '0;

  // shadow of the block's registers and LFO phase
  logic [31:0] model_phase;
  logic [30:0] model_inc;
  logic [15:0] model_amt;
  logic [15:0] model_lvl_in;
  logic [15:0] model_lvl_out;

  frame_t due_frames[$];
  int     mismatches = 0;
  int     frames_sent = 0;
  int     frames_checked = 0;
  int     settings_applied = 0;
  int     send_idle = 0;
  int     recv_stall = 0;

  stereo_autopan_lfo_gain_core #(
    .SINE_TABLE_BITS(TABLE_BITS),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_left(sample_left),
    .sample_right(sample_right),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_left(out_left),
    .out_right(out_right),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // sin(pi/2*t), t in Q2.30, result in Q.16
  function automatic logic [63:0] sine_magnitude(input logic [63:0] t);
    logic [63:0] t2, acc, s;
    t2 = (t * t) >> 30;
    acc = SIN_K9;
    acc = SIN_K7 - ((acc * t2) >> 30);
    acc = SIN_K5 - ((acc * t2) >> 30);
    acc = SIN_K3 - ((acc * t2) >> 30);
    acc = SIN_K1 - ((acc * t2) >> 30);
    s = (acc * t) >> 30;
    s = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return s;
  endfunction

  // unipolar LFO in Q1.15
  function automatic logic [63:0] lfo_of_phase(input logic [31:0] phase);
    logic [31:0] idx, quad, qsize, r, pos;
    logic [63:0] mag, u;
    idx = phase >> (32 - TABLE_BITS);
    quad = (idx >> (TABLE_BITS - 2)) & 32'd3;
    qsize = 32'd1 << (TABLE_BITS - 2);
    r = idx & (qsize - 32'd1);
    pos = quad[0] ? (qsize - r) : r;
    mag = sine_magnitude(64'(pos) << (32 - TABLE_BITS));
    u = quad[1] ? (64'd65536 - mag) : (64'd65536 + mag);
    return (u + 64'd2) >> 2;
  endfunction

  function automatic logic signed [SW-1:0] pan_sample(input logic signed [SW-1:0] x,
                                                      input logic [63:0] lfo,
                                                      input logic [63:0] lev);
    logic [63:0] a, m, g;
    longint prod, y;
    a = (model_amt > 16'd32768) ? 64'd32768 : 64'(model_amt);
    m = ((64'd32768 - a) * 64'd32768 + a * lfo + 64'd16384) >> 15;
    g = (m * lev + 64'd16384) >> 15;
    prod = longint'(x) * longint'(g);
    y = (prod + 64'sd2048) >>> 12;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    return y[SW-1:0];
  endfunction

  // panned word for one input word; advances the LFO phase
  function automatic frame_t pan_frame(input logic signed [SW-1:0] l,
                                       input logic signed [SW-1:0] r);
    frame_t f;
    logic [63:0] lev;
    lev = (64'(model_lvl_in) * 64'(model_lvl_out) + 64'd2048) >> 12;
    f.left = pan_sample(l, lfo_of_phase(model_phase), lev);
    f.right = pan_sample(r, lfo_of_phase(model_phase + 32'h8000_0000), lev);
    model_phase = model_phase + 32'(model_inc);
    return f;
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(7))
      0: s = S_MAX;
      1: s = S_MIN;
      2: s = SW'($signed($urandom_range(8191)) - 4096);
      default: s = SW'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_level();
    logic [15:0] v;
    case ($urandom_range(4))
      0: v = 16'd4096;
      1: v = 16'd0;
      2: v = 16'hFFFF;
      3: v = 16'($urandom_range(6000, 3000));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string field, input logic signed [SW-1:0] got,
                                 input logic signed [SW-1:0] want);
    $display("mismatch on %s of word %0d: got %0d, want %0d",
             field, frames_checked, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_frames.size() == 0) begin
        $display("unexpected word: left %0d right %0d", out_left, out_right);
        mismatches++;
      end else begin
        want = due_frames.pop_front();
        if (out_left !== want.left) report_mismatch("out_left", out_left, want.left);
        if (out_right !== want.right) report_mismatch("out_right", out_right, want.right);
      end
      frames_checked++;
    end
  end

  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_left <= l;
    sample_right <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_frames.push_back(pan_frame(l, r));
    frames_sent++;
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      apan_pkg::REG_PHASE_INC: model_inc = value;
      apan_pkg::REG_PAN_AMT:   model_amt = value[15:0];
      apan_pkg::REG_LEVEL_IN:  model_lvl_in = value[15:0];
      apan_pkg::REG_LEVEL_OUT: model_lvl_out = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [30:0] inc, input logic [30:0] amt,
                              input logic [30:0] lin, input logic [30:0] lout);
    write_reg(apan_pkg::REG_PHASE_INC, inc);
    write_reg(apan_pkg::REG_PAN_AMT, amt);
    write_reg(apan_pkg::REG_LEVEL_IN, lin);
    write_reg(apan_pkg::REG_LEVEL_OUT, lout);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  task automatic randomize_regs();
    logic [30:0] inc, amt;
    logic [15:0] a;
    case ($urandom_range(3))
      0: inc = '0;
      1: inc = 31'h7FFF_FFFF;
      2: inc = 31'($urandom_range(1 << 20));
      default: inc = 31'($urandom);
    endcase
    case ($urandom_range(3))
      0: a = 16'd0;
      1: a = 16'd32768;
      2: a = 16'($urandom_range(32768));
      default: a = 16'($urandom);
    endcase
    // junk in the unused upper bits must be dropped
    amt = {15'($urandom), a};
    program_regs(inc, amt, {15'($urandom), pick_level()}, {15'($urandom), pick_level()});
  endtask

  task automatic test_unity_passthrough();
    wait_drained();
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame('0, '0);
    send_frame(-24'sd1, 24'sd1);
    send_frame(24'sh555555, 24'shAAAAAA);
  endtask

  // eighth-turn steps walk every quadrant of the sine and wrap the phase
  task automatic test_full_depth_sweep();
    int k;
    wait_drained();
    program_regs(31'h2000_0000, 31'd32768, 31'd4096, 31'd4096);
    for (k = 0; k < 8; k++) begin
      send_frame(k[0] ? S_MIN : S_MAX, k[0] ? S_MAX : S_MIN);
    end
  endtask

  task automatic test_depth_clamp_and_masking();
    wait_drained();
    program_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_1000, 31'h0000_1000);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    send_frame(24'sd12345, -24'sd54321);
    send_frame(S_MAX, S_MIN);
  endtask

  task automatic test_level_extremes();
    wait_drained();
    program_regs(31'h0123_4567, 31'd16384, 31'hFFFF, 31'hFFFF);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(24'sd1, -24'sd1);
    wait_drained();
    program_regs(31'd0, 31'd0, 31'd0, 31'd4096);
    send_frame(S_MAX, S_MIN);
    // gain of one LSB: halves round toward plus infinity
    wait_drained();
    program_regs(31'd0, 31'd0, 31'd1, 31'd4096);
    send_frame(-24'sd2048, 24'sd2048);
    send_frame(-24'sd2049, 24'sd2047);
  endtask

  task automatic test_random_pacing(input int idle_pct, input int stall_pct,
                                    input int segments, input int per_segment);
    int s, k;
    for (s = 0; s < segments; s++) begin
      wait_drained();
      randomize_regs();
      if (s % 4 == 3) begin
        send_idle = 0;
        recv_stall = 0;
      end else begin
        send_idle = idle_pct;
        recv_stall = stall_pct;
      end
      for (k = 0; k < per_segment; k++) begin
        send_frame(random_sample(), random_sample());
      end
    end
    wait_drained();
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    model_phase = '0;
    model_inc = '0;
    model_amt = '0;
    model_lvl_in = 16'd4096;
    model_lvl_out = 16'd4096;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unity_passthrough();
    test_full_depth_sweep();
    test_depth_clamp_and_masking();
    test_level_extremes();
    test_random_pacing(0, 0, 8, 26);
    test_random_pacing(86, 0, 8, 26);
    test_random_pacing(0, 86, 8, 26);
    test_random_pacing(26, 26, 8, 26);

    wait_drained();
    if (due_frames.size() != 0) begin
      $display("%0d words never came out", due_frames.size());
      mismatches++;
    end
    $display("checked %0d of %0d stereo words over %0d register settings,",
             frames_checked, frames_sent, settings_applied);
    $display("with free-running, sender-idle, receiver-stall and mixed pacing");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
